/* rtl/pipeline_execute_stage_forwarding_assert.svh */
// Assertion macros shared by the checker of the execute stage.
`ifndef PIPELINE_EXECUTE_STAGE_FORWARDING_ASSERT_SVH
`define PIPELINE_EXECUTE_STAGE_FORWARDING_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define PESF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("execute stage check failed");

// Next-cycle implication, disabled while rst is high.
`define PESF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("execute stage check failed");

`endif

/* rtl/pesf_pkg.sv */
// Types and constants of the execute stage with forwarding.
`timescale 1ns / 1ps

package pesf_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic [4:0]         reg_num_type;
   typedef logic [2:0]         alu_op_type;
   typedef logic [8:0]         ctrl_word_type;
   typedef logic [4:0]         ctrl_pass_type;

   localparam alu_op_type ALU_AND = 3'd0;
   localparam alu_op_type ALU_OR  = 3'd1;
   localparam alu_op_type ALU_ADD = 3'd2;
   localparam alu_op_type ALU_SUB = 3'd6;

   localparam int unsigned CtrlRegDstBit = 8;
   localparam int unsigned CtrlAluSrcBit = 5;
   localparam int unsigned CtrlPassW     = 5;

   localparam ctrl_word_type CTRL_NONE = 9'd0;

   // Forwarding sources: the EX/MEM latch and the older entry behind it.
   typedef struct packed {
      reg_num_type latch_dest;
      word_type    latch_result;
      reg_num_type older_dest;
      word_type    older_result;
   } fwd_state_type;

   // One decoded instruction as held in the input register.
   typedef struct packed {
      logic          bubble;
      ctrl_word_type ctrl_word;
      alu_op_type    alu_op;
      word_type      rs_value;
      word_type      rt_value;
      reg_num_type   rs_num;
      reg_num_type   rt_num;
      reg_num_type   rd_num;
      word_type      imm_ext;
   } req_item_type;

endpackage

/* rtl/pesf_fwd_unit.sv */
// Operand forwarding: picks latch, older entry or register file value per source.
`timescale 1ns / 1ps

module pesf_fwd_unit import pesf_pkg::*; (
   input  fwd_state_type fwd_state,
   input  reg_num_type   rs_num,
   input  reg_num_type   rt_num,
   input  word_type      rs_value,
   input  word_type      rt_value,
   output word_type      op_a,
   output word_type      op_b
);

   // The latch wins over the older entry when both match.
   always_comb begin
      if (rs_num == fwd_state.latch_dest) begin
         op_a = fwd_state.latch_result;
      end else if (rs_num == fwd_state.older_dest) begin
         op_a = fwd_state.older_result;
      end else begin
         op_a = rs_value;
      end
   end

   always_comb begin
      if (rt_num == fwd_state.latch_dest) begin
         op_b = fwd_state.latch_result;
      end else if (rt_num == fwd_state.older_dest) begin
         op_b = fwd_state.older_result;
      end else begin
         op_b = rt_value;
      end
   end

endmodule

/* rtl/pesf_alu.sv */
// ALU of the execute stage: and, or, add, sub; other codes keep the old result.
`timescale 1ns / 1ps

module pesf_alu import pesf_pkg::*; (
   input  alu_op_type alu_op,
   input  word_type   op_a,
   input  word_type   op_b,
   input  word_type   old_result,
   output word_type   result
);

   always_comb begin
      case (alu_op)
         ALU_AND: result = op_a & op_b;
         ALU_OR:  result = op_a | op_b;
         ALU_ADD: result = op_a + op_b;
         ALU_SUB: result = op_a - op_b;
         default: result = old_result;
      endcase
   end

endmodule

/* rtl/pipeline_execute_stage_forwarding.sv */
// Top level of the execute stage with operand forwarding.
// A request passes the input register, then the EX/MEM latch, which drives the result.
// Throughput: one request per cycle unless the result side stalls.
// A request is taken whenever the input register is empty or its request advances.
// Reset (synchronous, active high) clears both valid flags, the EX/MEM latch and
// the older forwarding entry to zero.
`timescale 1ns / 1ps

module pipeline_execute_stage_forwarding import pesf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_bubble,
   input  logic [8:0]         req_ctrl_word,
   input  logic [2:0]         req_alu_op,
   input  logic signed [31:0] req_rs_value,
   input  logic signed [31:0] req_rt_value,
   input  logic [4:0]         req_rs_num,
   input  logic [4:0]         req_rt_num,
   input  logic [4:0]         req_rd_num,
   input  logic signed [31:0] req_imm_ext,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_valid_res,
   output logic signed [31:0] rsp_alu_result,
   output logic signed [31:0] rsp_store_data,
   output logic [4:0]         rsp_dest_num,
   output logic               rsp_dest_is_rd,
   output logic [4:0]         rsp_ctrl_out
);

   // Input register.
   req_item_type  item_ff;
   logic          item_valid_ff;

   // EX/MEM latch; it doubles as the result register.
   word_type      result_ff,   result_in;
   word_type      store_ff,    store_in;
   reg_num_type   dest_ff,     dest_in;
   logic          dest_sel_ff, dest_sel_in;
   ctrl_pass_type ctrl_ff,     ctrl_in;
   logic          exec_ff,     exec_in;
   logic          rsp_valid_ff;

   // Older forwarding entry.
   reg_num_type   older_dest_ff,   older_dest_in;
   word_type      older_result_ff, older_result_in;

   fwd_state_type fwd_state;
   word_type      op_a;
   word_type      op_b;
   word_type      op_b_sel;
   word_type      alu_out;
   logic          advance;
   logic          use_rd;
   logic          use_imm;

   // Advance the held request into the latch once the previous result is gone
   // or is being taken this cycle.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   // Payload of the input register needs no reset.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff.bubble    <= req_bubble;
         item_ff.ctrl_word <= req_ctrl_word;
         item_ff.alu_op    <= req_alu_op;
         item_ff.rs_value  <= req_rs_value;
         item_ff.rt_value  <= req_rt_value;
         item_ff.rs_num    <= req_rs_num;
         item_ff.rt_num    <= req_rt_num;
         item_ff.rd_num    <= req_rd_num;
         item_ff.imm_ext   <= req_imm_ext;
      end
   end

   assign fwd_state.latch_dest   = dest_ff;
   assign fwd_state.latch_result = result_ff;
   assign fwd_state.older_dest   = older_dest_ff;
   assign fwd_state.older_result = older_result_ff;

   pesf_fwd_unit u_fwd (
      .fwd_state (fwd_state),
      .rs_num    (item_ff.rs_num),
      .rt_num    (item_ff.rt_num),
      .rs_value  (item_ff.rs_value),
      .rt_value  (item_ff.rt_value),
      .op_a      (op_a),
      .op_b      (op_b)
   );

   assign use_rd   = item_ff.ctrl_word[CtrlRegDstBit];
   assign use_imm  = item_ff.ctrl_word[CtrlAluSrcBit];
   // Store data is taken before the immediate replaces the second operand.
   assign op_b_sel = use_imm ? item_ff.imm_ext : op_b;

   pesf_alu u_alu (
      .alu_op     (item_ff.alu_op),
      .op_a       (op_a),
      .op_b       (op_b_sel),
      .old_result (result_ff),
      .result     (alu_out)
   );

   // Next latch and older entry for the request in the input register.
   always_comb begin
      result_in       = result_ff;
      store_in        = store_ff;
      dest_in         = dest_ff;
      dest_sel_in     = dest_sel_ff;
      ctrl_in         = ctrl_ff;
      exec_in         = exec_ff;
      older_dest_in   = older_dest_ff;
      older_result_in = older_result_ff;
      if (item_ff.bubble) begin
         // Bubble: drop the latch, hold the older entry.
         result_in   = '0;
         store_in    = '0;
         dest_in     = '0;
         dest_sel_in = 1'b0;
         ctrl_in     = '0;
         exec_in     = 1'b0;
      end else if (item_ff.ctrl_word == CTRL_NONE) begin
         // Empty control word: drop the latch and the older entry.
         result_in       = '0;
         store_in        = '0;
         dest_in         = '0;
         dest_sel_in     = 1'b0;
         ctrl_in         = '0;
         exec_in         = 1'b0;
         older_dest_in   = '0;
         older_result_in = '0;
      end else begin
         // Execute: shift the latch into the older entry, load the new values.
         older_dest_in   = dest_ff;
         older_result_in = result_ff;
         result_in       = alu_out;
         store_in        = op_b;
         dest_sel_in     = use_rd;
         dest_in         = use_rd ? item_ff.rd_num : item_ff.rt_num;
         ctrl_in         = item_ff.ctrl_word[CtrlPassW-1:0];
         exec_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff       <= '0;
         store_ff        <= '0;
         dest_ff         <= '0;
         dest_sel_ff     <= 1'b0;
         ctrl_ff         <= '0;
         exec_ff         <= 1'b0;
         older_dest_ff   <= '0;
         older_result_ff <= '0;
      end else if (advance) begin
         result_ff       <= result_in;
         store_ff        <= store_in;
         dest_ff         <= dest_in;
         dest_sel_ff     <= dest_sel_in;
         ctrl_ff         <= ctrl_in;
         exec_ff         <= exec_in;
         older_dest_ff   <= older_dest_in;
         older_result_ff <= older_result_in;
      end
   end

   // Every request gives one result, bubble or not.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valid_res  = exec_ff;
   assign rsp_alu_result = result_ff;
   assign rsp_store_data = store_ff;
   assign rsp_dest_num   = dest_ff;
   assign rsp_dest_is_rd = dest_sel_ff;
   assign rsp_ctrl_out   = ctrl_ff;

endmodule

/* rtl/pesf_checker.sv */
// Port-level checker of the execute stage, bound to the top level.
`timescale 1ns / 1ps
`include "pipeline_execute_stage_forwarding_assert.svh"

module pesf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_valid_res,
   input logic signed [31:0] rsp_alu_result,
   input logic signed [31:0] rsp_store_data,
   input logic [4:0]         rsp_dest_num,
   input logic               rsp_dest_is_rd,
   input logic [4:0]         rsp_ctrl_out
);

   `PESF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_alu_result) && $stable(rsp_dest_num))
   `PESF_ASSERT_IMPLY(a_no_exec_zero, clock, reset, rsp_valid && !rsp_valid_res, rsp_alu_result == 32'sd0 && rsp_store_data == 32'sd0 && rsp_dest_num == 5'd0 && !rsp_dest_is_rd && rsp_ctrl_out == 5'd0)
   `PESF_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `PESF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind pipeline_execute_stage_forwarding pesf_checker u_pesf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_valid_res  (rsp_valid_res),
   .rsp_alu_result (rsp_alu_result),
   .rsp_store_data (rsp_store_data),
   .rsp_dest_num   (rsp_dest_num),
   .rsp_dest_is_rd (rsp_dest_is_rd),
   .rsp_ctrl_out   (rsp_ctrl_out)
);

/* test/tb_pipeline_execute_stage_forwarding.sv */
// Self-checking testbench for the execute stage with operand forwarding.
`timescale 1ns / 1ps

module tb_pipeline_execute_stage_forwarding;
   import pesf_pkg::*;

   // Control word pieces used to build instructions.
   localparam ctrl_word_type CTRL_REG_DST = ctrl_word_type'(1) << CtrlRegDstBit;
   localparam ctrl_word_type CTRL_ALU_IMM = ctrl_word_type'(1) << CtrlAluSrcBit;
   localparam ctrl_word_type CTRL_PASS_1  = 9'h001;
   localparam ctrl_word_type CTRL_ALL     = 9'h1ff;

   // Unlisted ALU codes; the stage must keep its old result for these.
   localparam alu_op_type ALU_KEEP_3 = 3'd3;
   localparam alu_op_type ALU_KEEP_4 = 3'd4;
   localparam alu_op_type ALU_KEEP_5 = 3'd5;
   localparam alu_op_type ALU_KEEP_7 = 3'd7;

   localparam word_type WORD_MAX  = 32'sh7fff_ffff;
   localparam word_type WORD_MIN  = 32'sh8000_0000;
   localparam word_type WORD_ONES = 32'shffff_ffff;

   localparam int CYCLE_LIMIT    = 100000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int REPORT_LIMIT   = 30;

   typedef struct packed {
      logic        valid_res;
      word_type    alu_result;
      word_type    store_data;
      reg_num_type dest_num;
      logic        dest_is_rd;
      ctrl_pass_type ctrl_out;
   } stage_out_type;

   // Block ports.
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_bubble = 1'b0;
   ctrl_word_type req_ctrl_word = '0;
   alu_op_type    req_alu_op = '0;
   word_type      req_rs_value = '0;
   word_type      req_rt_value = '0;
   reg_num_type   req_rs_num = '0;
   reg_num_type   req_rt_num = '0;
   reg_num_type   req_rd_num = '0;
   word_type      req_imm_ext = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_valid_res;
   word_type      rsp_alu_result;
   word_type      rsp_store_data;
   reg_num_type   rsp_dest_num;
   logic          rsp_dest_is_rd;
   ctrl_pass_type rsp_ctrl_out;

   // Shadow copy of the EX/MEM latch and the older forwarding entry.
   word_type      lat_result   = '0;
   word_type      lat_store    = '0;
   reg_num_type   lat_dest     = '0;
   logic          lat_dest_rd  = 1'b0;
   ctrl_pass_type lat_ctrl     = '0;
   reg_num_type   old_dest     = '0;
   word_type      old_result   = '0;

   stage_out_type ex_mem_expected[$];

   // Idling switches and run statistics.
   bit  idle_enable = 1'b1;
   int  mismatch_count = 0;
   int  requests_taken = 0;
   int  results_checked = 0;
   int  bubbles_taken = 0;
   int  flushes_taken = 0;
   int  operands_forwarded = 0;
   int  cycle_count = 0;

   // Destinations of the last two real instructions sent, to build dependency chains.
   reg_num_type recent_dest[2] = '{default: '0};

   pipeline_execute_stage_forwarding uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_bubble     (req_bubble),
      .req_ctrl_word  (req_ctrl_word),
      .req_alu_op     (req_alu_op),
      .req_rs_value   (req_rs_value),
      .req_rt_value   (req_rt_value),
      .req_rs_num     (req_rs_num),
      .req_rt_num     (req_rt_num),
      .req_rd_num     (req_rd_num),
      .req_imm_ext    (req_imm_ext),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_alu_result (rsp_alu_result),
      .rsp_store_data (rsp_store_data),
      .rsp_dest_num   (rsp_dest_num),
      .rsp_dest_is_rd (rsp_dest_is_rd),
      .rsp_ctrl_out   (rsp_ctrl_out)
   );

   always #10 clock = ~clock;

   // Hard stop: no correct run comes anywhere near this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                  ex_mem_expected.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Stall the result side about ten percent of the time while idling is on.
   always @(posedge clock) begin
      rsp_ready <= !idle_enable || ($urandom_range(99) >= 10);
   end

   // Advance the shadow stage by one request and return the result it leaves
   // in the EX/MEM latch.
   function automatic stage_out_type ex_mem_next(input req_item_type item);
      word_type      opa;
      word_type      opb;
      word_type      opb_alu;
      stage_out_type out;
      if (item.bubble) begin
         // Bubble: clear the latch, keep the older entry.
         {lat_result, lat_store, lat_dest, lat_dest_rd, lat_ctrl} = '0;
         bubbles_taken++;
      end else if (item.ctrl_word == CTRL_NONE) begin
         // Empty control word: flush the latch and the older entry alike.
         {lat_result, lat_store, lat_dest, lat_dest_rd, lat_ctrl} = '0;
         old_dest   = '0;
         old_result = '0;
         flushes_taken++;
      end else begin
         // Latch match wins over the older entry; register zero is not special.
         if (item.rs_num == lat_dest) opa = lat_result;
         else if (item.rs_num == old_dest) opa = old_result;
         else opa = item.rs_value;
         if (item.rt_num == lat_dest) opb = lat_result;
         else if (item.rt_num == old_dest) opb = old_result;
         else opb = item.rt_value;
         if (item.rs_num == lat_dest || item.rs_num == old_dest) operands_forwarded++;
         if (item.rt_num == lat_dest || item.rt_num == old_dest) operands_forwarded++;

         old_dest    = lat_dest;
         old_result  = lat_result;
         lat_store   = opb;
         opb_alu     = item.ctrl_word[CtrlAluSrcBit] ? item.imm_ext : opb;
         lat_dest_rd = item.ctrl_word[CtrlRegDstBit];
         lat_dest    = lat_dest_rd ? item.rd_num : item.rt_num;
         lat_ctrl    = item.ctrl_word[CtrlPassW-1:0];
         case (item.alu_op)
            ALU_AND: lat_result = opa & opb_alu;
            ALU_OR:  lat_result = opa | opb_alu;
            ALU_ADD: lat_result = opa + opb_alu;
            ALU_SUB: lat_result = opa - opb_alu;
            default: ;
         endcase
      end
      out.valid_res  = !item.bubble && (item.ctrl_word != CTRL_NONE);
      out.alu_result = lat_result;
      out.store_data = lat_store;
      out.dest_num   = lat_dest;
      out.dest_is_rd = lat_dest_rd;
      out.ctrl_out   = lat_ctrl;
      return out;
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
      end
   endfunction

   // Check each result against the oldest one due, then predict from each
   // request taken at this edge. Both handshakes are sampled before the edge
   // takes effect, so the order is fixed.
   always @(posedge clock) begin : result_check
      stage_out_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (ex_mem_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result with none due, expected nothing actual %h/%h",
                           $time, rsp_valid_res, rsp_alu_result);
            end else begin
               due = ex_mem_expected.pop_front();
               check_field("valid_res",  32'(due.valid_res),  32'(rsp_valid_res));
               check_field("alu_result", due.alu_result,      rsp_alu_result);
               check_field("store_data", due.store_data,      rsp_store_data);
               check_field("dest_num",   32'(due.dest_num),   32'(rsp_dest_num));
               check_field("dest_is_rd", 32'(due.dest_is_rd), 32'(rsp_dest_is_rd));
               check_field("ctrl_out",   32'(due.ctrl_out),   32'(rsp_ctrl_out));
            end
         end
         if (req_valid && req_ready) begin
            requests_taken++;
            ex_mem_expected.push_back(ex_mem_next('{req_bubble, req_ctrl_word, req_alu_op,
               req_rs_value, req_rt_value, req_rs_num, req_rt_num, req_rd_num,
               req_imm_ext}));
         end
      end
   end

   // Offer one request and hold it until the stage takes it. Any idle gap
   // comes first, so valid is set only once in the step it was accepted in.
   task automatic send_request(input req_item_type item);
      if (idle_enable && $urandom_range(99) < 4) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_bubble    <= item.bubble;
      req_ctrl_word <= item.ctrl_word;
      req_alu_op    <= item.alu_op;
      req_rs_value  <= item.rs_value;
      req_rt_value  <= item.rt_value;
      req_rs_num    <= item.rs_num;
      req_rt_num    <= item.rt_num;
      req_rd_num    <= item.rd_num;
      req_imm_ext   <= item.imm_ext;
      do @(posedge clock); while (!req_ready);
      // Remember where a real instruction writes, for dependent follow-ups.
      if (!item.bubble && item.ctrl_word != CTRL_NONE) begin
         recent_dest[1] = recent_dest[0];
         recent_dest[0] = item.ctrl_word[CtrlRegDstBit] ? item.rd_num : item.rt_num;
      end
   endtask

   function automatic req_item_type make_instr(input ctrl_word_type ctrl, input alu_op_type op,
                                               input reg_num_type rs_n, input reg_num_type rt_n,
                                               input reg_num_type rd_n, input word_type rs_v,
                                               input word_type rt_v, input word_type imm);
      return '{1'b0, ctrl, op, rs_v, rt_v, rs_n, rt_n, rd_n, imm};
   endfunction

   // Mostly random words, with the extremes thrown in now and then.
   function automatic word_type rand_word();
      case ($urandom_range(9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return WORD_ONES;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_item_type bubble_item();
      req_item_type item;
      item        = make_instr(ctrl_word_type'($urandom), alu_op_type'($urandom),
                               reg_num_type'($urandom), reg_num_type'($urandom),
                               reg_num_type'($urandom), $urandom, $urandom, $urandom);
      item.bubble = 1'b1;
      return item;
   endfunction

   // Extremes, every ALU code, bubbles, flushes and the forwarding corners.
   task automatic test_directed_cases();
      // Add and subtract at the wrap points, no dependencies.
      send_request(make_instr(CTRL_REG_DST | CTRL_PASS_1, ALU_ADD, 5'd2, 5'd3, 5'd1,
                              WORD_MAX, 32'sd1, '0));
      send_request(make_instr(CTRL_REG_DST | 9'h01f, ALU_SUB, 5'd4, 5'd5, 5'd6,
                              WORD_MIN, 32'sd1, '0));
      // Take rs from the latch (r6) and rt from the older entry (r1).
      send_request(make_instr(CTRL_REG_DST | 9'h00a, ALU_AND, 5'd6, 5'd1, 5'd8,
                              32'sh1234_5678, 32'sh0f0f_0f0f, '0));
      // Immediate as second operand, destination rt; store data keeps rt.
      send_request(make_instr(CTRL_ALU_IMM | 9'h015, ALU_OR, 5'd8, 5'd7, 5'd9,
                              '0, 32'sh5555_aaaa, WORD_ONES));
      // Unlisted codes keep the result while the rest of the latch moves on.
      send_request(make_instr(CTRL_REG_DST | 9'h003, ALU_KEEP_3, 5'd10, 5'd11, 5'd12,
                              32'sd5, 32'sd6, '0));
      send_request(make_instr(CTRL_ALU_IMM | 9'h004, ALU_KEEP_4, 5'd12, 5'd13, 5'd14,
                              32'sd5, 32'sd6, WORD_MIN));
      send_request(make_instr(CTRL_REG_DST | 9'h010, ALU_KEEP_5, 5'd13, 5'd12, 5'd15,
                              32'sd5, 32'sd6, '0));
      send_request(make_instr(CTRL_ALL, ALU_KEEP_7, 5'd31, 5'd31, 5'd31,
                              WORD_ONES, WORD_ONES, WORD_ONES));
      // Register zero as destination, then read back through forwarding.
      send_request(make_instr(CTRL_REG_DST | CTRL_PASS_1, ALU_ADD, 5'd16, 5'd17, 5'd0,
                              32'sd100, 32'sd23, '0));
      send_request(make_instr(CTRL_REG_DST | 9'h002, ALU_SUB, 5'd0, 5'd0, 5'd18,
                              32'sd1, 32'sd2, '0));
      // Two writes to r9 in a row: the latch wins over the older entry.
      send_request(make_instr(CTRL_REG_DST | 9'h008, ALU_ADD, 5'd20, 5'd21, 5'd9,
                              32'sd11, 32'sd22, '0));
      send_request(make_instr(CTRL_REG_DST | 9'h008, ALU_OR, 5'd22, 5'd23, 5'd9,
                              32'sh0000_ff00, 32'sh00ff_0000, '0));
      send_request(make_instr(CTRL_REG_DST | 9'h008, ALU_ADD, 5'd9, 5'd9, 5'd24,
                              32'sd0, 32'sd0, '0));
      // Bubble: latch cleared, older entry (r9) survives into the next request.
      send_request(bubble_item());
      send_request(make_instr(CTRL_REG_DST | 9'h001, ALU_ADD, 5'd24, 5'd0, 5'd25,
                              32'sd3, 32'sd4, '0));
      // Flush with an all-zero control word, then read registers that were live.
      send_request(make_instr(CTRL_NONE, ALU_ADD, 5'd25, 5'd25, 5'd26,
                              WORD_ONES, WORD_ONES, WORD_ONES));
      send_request(make_instr(CTRL_REG_DST | 9'h001, ALU_ADD, 5'd0, 5'd25, 5'd27,
                              32'sd77, 32'sd88, '0));
      // All fields at their top and bottom ends.
      send_request(make_instr(CTRL_ALL, ALU_SUB, 5'd31, 5'd30, 5'd29,
                              WORD_MIN, WORD_MAX, WORD_MAX));
      send_request(make_instr(CTRL_ALU_IMM | CTRL_PASS_1, ALU_ADD, 5'd0, 5'd0, 5'd0,
                              '0, '0, WORD_MIN));
      send_request(bubble_item());
      send_request(bubble_item());
   endtask

   // Dependent instruction streams: most sources read one of the last two
   // destinations, a few bubbles and flushes break the chain.
   task automatic test_forwarding_chains(input int count);
      req_item_type item;
      for (int i = 0; i < count; i++) begin
         item = make_instr(ctrl_word_type'($urandom), alu_op_type'($urandom),
                           reg_num_type'($urandom), reg_num_type'($urandom),
                           reg_num_type'($urandom), rand_word(), rand_word(), rand_word());
         if ($urandom_range(99) < 85)
            case ($urandom_range(3))
               0: item.alu_op = ALU_AND;
               1: item.alu_op = ALU_OR;
               2: item.alu_op = ALU_ADD;
               default: item.alu_op = ALU_SUB;
            endcase
         if ($urandom_range(99) < 70) item.rs_num = recent_dest[$urandom_range(1)];
         if ($urandom_range(99) < 70) item.rt_num = recent_dest[$urandom_range(1)];
         if (item.ctrl_word == CTRL_NONE) item.ctrl_word = CTRL_PASS_1;
         case ($urandom_range(99))
            0, 1, 2: item.bubble = 1'b1;
            3:       item.ctrl_word = CTRL_NONE;
            default: ;
         endcase
         send_request(item);
      end
   endtask

   // Loose requests: random everything, many bubbles and flushes.
   task automatic test_random_noise(input int count);
      req_item_type item;
      for (int i = 0; i < count; i++) begin
         item        = make_instr(ctrl_word_type'($urandom), alu_op_type'($urandom),
                                  reg_num_type'($urandom), reg_num_type'($urandom),
                                  reg_num_type'($urandom), $urandom, $urandom, $urandom);
         item.bubble = ($urandom_range(99) < 30);
         if ($urandom_range(99) < 15) item.ctrl_word = CTRL_NONE;
         send_request(item);
      end
   endtask

   // Full rate in both directions: no sender gaps, no result stalls.
   task automatic test_back_to_back(input int count);
      idle_enable = 1'b0;
      test_forwarding_chains(count);
      idle_enable = 1'b1;
   endtask

   initial begin
      // Hold reset from the start, release it once and never again.
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_forwarding_chains(350);
      test_random_noise(150);
      test_back_to_back(200);

      // Drop valid, drain what is still due, then watch for strays.
      req_valid <= 1'b0;
      while (ex_mem_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d bubbles, %0d flushes, %0d forwarded operands),",
               requests_taken, bubbles_taken, flushes_taken, operands_forwarded);
      $display("with %0d results checked and %0d mismatches.", results_checked,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
